// File: hw/rtl/tpw_pkg.sv
// ----------------------------------------------------------------------------
// tpw_pkg
// Shared types and constants of the transfer progress watchdog.
// ----------------------------------------------------------------------------
package tpw_pkg;

  localparam int unsigned TimeW     = 48;
  localparam int unsigned RateW     = 32;
  localparam int unsigned ApbDataW  = 64;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned TicksPerSecondDefault = 1000000;

  localparam logic [TimeW-1:0] HeaderDeadlineRst    = {TimeW{1'b1}};
  localparam logic [TimeW-1:0] OperationDeadlineRst = '0;
  localparam logic [TimeW-1:0] StallIntervalRst     = TimeW'(10000000);
  localparam logic [RateW-1:0] MinimumRateRst       = '0;

  typedef enum logic [1:0] {
    ActStart    = 2'd0,
    ActHeader   = 2'd1,
    ActProgress = 2'd2
  } tpw_action_e;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrHeader    = 3'd1,
    ErrOperation = 3'd2,
    ErrStall     = 3'd3,
    ErrSlow      = 3'd4
  } tpw_err_e;

  typedef enum logic [1:0] {
    RegHeaderDeadline    = 2'd0,
    RegOperationDeadline = 2'd1,
    RegStallInterval     = 2'd2,
    RegMinimumRate       = 2'd3
  } tpw_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] header_deadline;
    logic [TimeW-1:0] operation_deadline;
    logic [TimeW-1:0] stall_interval;
    logic [RateW-1:0] minimum_rate;
  } tpw_cfg_t;

endpackage

// File: hw/rtl/tpw_regs.sv
// ----------------------------------------------------------------------------
// tpw_regs
// APB configuration registers of the watchdog, one register per 8 bytes.
// ----------------------------------------------------------------------------
module tpw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpw_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tpw_pkg::ApbDataW-1:0]  pwdata,
  output logic [tpw_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output tpw_pkg::tpw_cfg_t             cfg_o
);
  import tpw_pkg::*;

  tpw_cfg_t cfg_q, cfg_d;
  tpw_reg_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = tpw_reg_e'(paddr[ApbAddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegHeaderDeadline:    cfg_d.header_deadline    = pwdata[TimeW-1:0];
        RegOperationDeadline: cfg_d.operation_deadline = pwdata[TimeW-1:0];
        RegStallInterval:     cfg_d.stall_interval     = pwdata[TimeW-1:0];
        RegMinimumRate:       cfg_d.minimum_rate       = pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegHeaderDeadline:    prdata = ApbDataW'(cfg_q.header_deadline);
      RegOperationDeadline: prdata = ApbDataW'(cfg_q.operation_deadline);
      RegStallInterval:     prdata = ApbDataW'(cfg_q.stall_interval);
      RegMinimumRate:       prdata = ApbDataW'(cfg_q.minimum_rate);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_deadline    <= HeaderDeadlineRst;
      cfg_q.operation_deadline <= OperationDeadlineRst;
      cfg_q.stall_interval     <= StallIntervalRst;
      cfg_q.minimum_rate       <= MinimumRateRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/transfer_progress_watchdog.sv
// ----------------------------------------------------------------------------
// transfer_progress_watchdog
// Decides on each progress report whether a transfer must be aborted:
// header timeout, operation timeout, stall, or slow recent rate.
//
//   channel  direction  handshake                fields
//   in       sink       in_valid_i / in_ready_o  action, time_now, bytes
//   out      source     out_valid_o/out_ready_i  abort, error_code
//   cfg      APB slave  psel/penable/pready      4 registers at 8*i
//
// One transfer per cycle sustained while out_ready_i is high. After the
// input register come timing checks and state update, rate partial
// products, product sums, then compare and error latch.
// Reset clears the state at once. Each stage holds while the one after it
// is full and stalled, so a full output register alone does not stop input.
// ----------------------------------------------------------------------------
module transfer_progress_watchdog #(
  parameter int unsigned TICKS_PER_SECOND = tpw_pkg::TicksPerSecondDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpw_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tpw_pkg::ApbDataW-1:0]  pwdata,
  output logic [tpw_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [tpw_pkg::TimeW-1:0]     time_now_i,
  input  logic [tpw_pkg::TimeW-1:0]     download_bytes_i,
  input  logic [tpw_pkg::TimeW-1:0]     upload_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          abort_o,
  output logic [2:0]                    error_code_o
);
  import tpw_pkg::*;

  localparam int unsigned TW    = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned HalfW = TimeW / 2;
  localparam int unsigned LpW   = HalfW + TW;
  localparam int unsigned RpW   = HalfW + RateW;
  localparam int unsigned LW    = TimeW + TW;
  localparam int unsigned RW    = TimeW + RateW;
  localparam int unsigned CW    = (LW > RW) ? LW : RW;
  localparam logic [TW-1:0] Ticks = TW'(TICKS_PER_SECOND);

  tpw_cfg_t cfg;

  tpw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // flow control
  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;
  logic adv0, adv1, adv2, adv3;

  assign rdyo       = !vo_q || out_ready_i;
  assign rdy3       = !v3_q || rdyo;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = !v0_q || rdy1;
  assign adv0       = v0_q && rdy1;
  assign adv1       = v1_q && rdy2;
  assign adv2       = v2_q && rdy3;
  assign adv3       = v3_q && rdyo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (in_ready_o) v0_q <= in_valid_i;
      if (rdy1)       v1_q <= v0_q;
      if (rdy2)       v2_q <= v1_q;
      if (rdy3)       v3_q <= v2_q;
      if (rdyo)       vo_q <= v3_q;
    end
  end

  // stage 0: input register
  logic [1:0]       act_q;
  logic [TimeW-1:0] now_q, dl_q, ul_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      now_q <= time_now_i;
      dl_q  <= download_bytes_i;
      ul_q  <= upload_bytes_i;
    end
  end

  // transfer state
  logic             hdr_seen_q, hdr_seen_d;
  logic [TimeW-1:0] hdr_time_q, hdr_time_d;
  logic [TimeW-1:0] prog_time_q, prog_time_d;
  logic             prog_valid_q, prog_valid_d;
  logic [TimeW-1:0] last_bytes_q, last_bytes_d;

  logic [TimeW-1:0] bytes, ptime, elapsed, diff;
  logic             grew, hdr_to, op_to, stall, slow_ok;
  tpw_err_e         code1_d;
  logic             chk1_d;

  always_comb begin
    bytes   = (dl_q > ul_q) ? dl_q : ul_q;
    ptime   = prog_valid_q ? prog_time_q : hdr_time_q;
    elapsed = (now_q >= ptime) ? (now_q - ptime) : '0;
    grew    = bytes > last_bytes_q;
    diff    = bytes - last_bytes_q;
    hdr_to  = !hdr_seen_q && (now_q > cfg.header_deadline);
    op_to   = (cfg.operation_deadline != '0) && hdr_seen_q &&
              (now_q > cfg.operation_deadline);
    stall   = elapsed > cfg.stall_interval;
    slow_ok = grew && (now_q >= hdr_time_q) &&
              ((now_q - hdr_time_q) >= cfg.stall_interval);

    hdr_seen_d   = hdr_seen_q;
    hdr_time_d   = hdr_time_q;
    prog_time_d  = prog_time_q;
    prog_valid_d = prog_valid_q;
    last_bytes_d = last_bytes_q;
    code1_d      = ErrNone;
    chk1_d       = 1'b0;

    case (tpw_action_e'(act_q))
      ActStart: begin
        hdr_time_d = now_q;
      end
      ActHeader: begin
        hdr_seen_d = 1'b1;
        hdr_time_d = now_q;
      end
      ActProgress: begin
        if (hdr_to) begin
          code1_d = ErrHeader;
        end else if (op_to) begin
          code1_d = ErrOperation;
        end else begin
          prog_valid_d = 1'b1;
          prog_time_d  = grew ? now_q : ptime;
          last_bytes_d = grew ? bytes : last_bytes_q;
          if (stall) begin
            code1_d = ErrStall;
          end else begin
            chk1_d = slow_ok;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_seen_q   <= 1'b0;
      hdr_time_q   <= '0;
      prog_time_q  <= '0;
      prog_valid_q <= 1'b0;
      last_bytes_q <= '0;
    end else if (adv0) begin
      hdr_seen_q   <= hdr_seen_d;
      hdr_time_q   <= hdr_time_d;
      prog_time_q  <= prog_time_d;
      prog_valid_q <= prog_valid_d;
      last_bytes_q <= last_bytes_d;
    end
  end

  // stage 1: operands of the rate check
  tpw_err_e         code1_q;
  logic             chk1_q;
  logic [TimeW-1:0] diff1_q, el1_q;

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      code1_q <= code1_d;
      chk1_q  <= chk1_d;
      diff1_q <= diff;
      el1_q   <= elapsed;
    end
  end

  // stage 2: partial products
  tpw_err_e       code2_q;
  logic           chk2_q;
  logic [LpW-1:0] lp_lo_q, lp_hi_q;
  logic [RpW-1:0] rp_lo_q, rp_hi_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      code2_q <= code1_q;
      chk2_q  <= chk1_q;
      lp_lo_q <= LpW'(diff1_q[HalfW-1:0]) * LpW'(Ticks);
      lp_hi_q <= LpW'(diff1_q[TimeW-1:HalfW]) * LpW'(Ticks);
      rp_lo_q <= RpW'(cfg.minimum_rate) * RpW'(el1_q[HalfW-1:0]);
      rp_hi_q <= RpW'(cfg.minimum_rate) * RpW'(el1_q[TimeW-1:HalfW]);
    end
  end

  // stage 3: full products
  tpw_err_e      code3_q;
  logic          chk3_q;
  logic [LW-1:0] lhs_q;
  logic [RW-1:0] rhs_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      code3_q <= code2_q;
      chk3_q  <= chk2_q;
      lhs_q   <= LW'({lp_hi_q, {HalfW{1'b0}}}) + LW'(lp_lo_q);
      rhs_q   <= RW'({rp_hi_q, {HalfW{1'b0}}}) + RW'(rp_lo_q);
    end
  end

  // output stage: compare and error latch
  logic     slow;
  tpw_err_e code, latched_q, latched_d;
  logic     abort_q;
  tpw_err_e err_q;

  always_comb begin
    slow = chk3_q && (CW'(lhs_q) < CW'(rhs_q));
    code = slow ? ErrSlow : code3_q;
    latched_d = (latched_q == ErrNone) ? code : latched_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= ErrNone;
    end else if (adv3) begin
      latched_q <= latched_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      abort_q <= (code != ErrNone);
      err_q   <= latched_d;
    end
  end

  assign out_valid_o  = vo_q;
  assign abort_o      = abort_q;
  assign error_code_o = err_q;

endmodule
